// ===== design/cit_pkg.sv =====
// Shared types, codes and sizes for the content index table.
package cit_pkg;

  // Table geometry
  localparam int unsigned DEPTH  = 256;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned DL_W   = 10;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 3;

  localparam logic [DL_W-1:0] DL_MAX       = {DL_W{1'b1}};
  localparam logic [DL_W-1:0] CEIL_DEFAULT = DL_W'(999);

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEREGISTER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE       = 2'd3;

  // Result codes
  localparam logic [STAT_W-1:0] ST_REGISTERED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL           = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND          = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND      = 3'd4;
  localparam logic [STAT_W-1:0] ST_DEREGISTERED   = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOT_REGISTERED = 3'd6;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic [KEY_W-1:0]  content;
    logic [KEY_W-1:0]  peer;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [DL_W-1:0]   downloads;
  } cit_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch request word, restart scan
    logic scan_en;  // step the slot scan
    logic finish;   // commit updates and load the result word
  } cit_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // all filled slots compared
    logic out_busy;   // result register full and not being taken
    logic req_none;   // incoming request carries the unused mode
  } cit_sts_t;

endpackage

// ===== design/cit_ctrl.sv =====
// Request sequencer for the content index table.
module cit_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cit_pkg::cit_sts_t sts_i,
  output cit_pkg::cit_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // unused mode is swallowed without a result
          if (!sts_i.req_none) state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Only one command at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.scan_en, cmd_o.finish}))
    else $error("more than one datapath command");

  // A finish always returns to idle, ready for the next word
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o)
    else $error("not idle after finish");

  // Scan ends in the result state
  a_scan_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_en && sts_i.scan_done) |=> (state_q == S_FIN))
    else $error("scan end lost");

endmodule

// ===== design/cit_dp.sv =====
// Slot memory, live bits, scan comparators and result register.
module cit_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cit_pkg::cit_cmd_t               cmd_i,
  output cit_pkg::cit_sts_t               sts_o,
  input  logic [cit_pkg::MODE_W-1:0]      mode_i,
  input  logic [cit_pkg::KEY_W-1:0]       content_key_i,
  input  logic [cit_pkg::KEY_W-1:0]       peer_key_i,
  input  logic [cit_pkg::IP_W-1:0]        peer_ip_i,
  input  logic [cit_pkg::PORT_W-1:0]      peer_port_i,
  input  logic                            cfg_valid_i,
  input  logic [cit_pkg::DL_W-1:0]        cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cit_pkg::STAT_W-1:0]      status_o,
  output logic [cit_pkg::KEY_W-1:0]       found_peer_o,
  output logic [cit_pkg::IP_W-1:0]        found_ip_o,
  output logic [cit_pkg::PORT_W-1:0]      found_port_o
);

  // Request word
  logic [cit_pkg::MODE_W-1:0] mode_q;
  logic [cit_pkg::KEY_W-1:0]  content_q, peer_q;
  logic [cit_pkg::IP_W-1:0]   ip_q;
  logic [cit_pkg::PORT_W-1:0] port_q;

  // Table state
  cit_pkg::cit_entry_t        slot_mem_q [cit_pkg::DEPTH];
  logic [cit_pkg::DEPTH-1:0]  live_q;
  logic [cit_pkg::CNT_W-1:0]  fill_q;
  logic [cit_pkg::DL_W-1:0]   ceil_q;

  // Scan pipeline
  logic [cit_pkg::CNT_W-1:0]  addr_q;
  logic                       rv_q;
  logic [cit_pkg::IDX_W-1:0]  ridx_q;
  cit_pkg::cit_entry_t        rdata_q;
  logic                       rlive_q;
  logic                       rd_en;

  // Match tracking
  logic                       found_q, hit_q;
  logic [cit_pkg::IDX_W-1:0]  pick_q;
  logic [cit_pkg::DL_W-1:0]   best_q;
  logic [cit_pkg::KEY_W-1:0]  bpeer_q;
  logic [cit_pkg::IP_W-1:0]   bip_q;
  logic [cit_pkg::PORT_W-1:0] bport_q;

  // Result word
  logic                       out_valid_q;
  logic [cit_pkg::STAT_W-1:0] out_status_q;
  logic [cit_pkg::KEY_W-1:0]  out_peer_q;
  logic [cit_pkg::IP_W-1:0]   out_ip_q;
  logic [cit_pkg::PORT_W-1:0] out_port_q;

  // Commit signals
  logic [cit_pkg::STAT_W-1:0] status_d;
  logic                       wr_en, live_set, live_clr;
  logic [cit_pkg::IDX_W-1:0]  wr_addr;
  cit_pkg::cit_entry_t        wr_data;
  logic [cit_pkg::DL_W-1:0]   dl_inc;

  logic slot_live, content_eq, pair_eq, below_best;

  assign sts_o.scan_done = (addr_q == fill_q) && !rv_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.req_none  = (mode_i == cit_pkg::MODE_NONE);

  assign rd_en = cmd_i.scan_en && (addr_q != fill_q);

  // Compare stage on the registered slot word
  assign slot_live  = rv_q && rlive_q;
  assign content_eq = slot_live && (rdata_q.content == content_q);
  assign pair_eq    = content_eq && (rdata_q.peer == peer_q);
  assign below_best = content_eq && (rdata_q.downloads < best_q);

  // Request word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      content_q <= content_key_i;
      peer_q    <= peer_key_i;
      ip_q      <= peer_ip_i;
      port_q    <= peer_port_i;
    end
  end

  // Download ceiling register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= cit_pkg::CEIL_DEFAULT;
    end else if (cfg_valid_i) begin
      ceil_q <= cfg_data_i;
    end
  end

  // Scan address and read-valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      rv_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        addr_q <= '0;
      end else if (rd_en) begin
        addr_q <= addr_q + cit_pkg::CNT_W'(1);
      end
      rv_q <= rd_en;
    end
  end

  // Slot memory: one read, one write port; live bit read alongside
  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata_q <= slot_mem_q[addr_q[cit_pkg::IDX_W-1:0]];
      rlive_q <= live_q[addr_q[cit_pkg::IDX_W-1:0]];
      ridx_q  <= addr_q[cit_pkg::IDX_W-1:0];
    end
  end

  // Match tracking: first pair match, least count below ceiling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (pair_eq && !found_q) found_q <= 1'b1;
      if (below_best) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_q <= ceil_q;
    end else if (mode_q == cit_pkg::MODE_SEARCH) begin
      if (below_best) begin
        best_q  <= rdata_q.downloads;
        pick_q  <= ridx_q;
        bpeer_q <= rdata_q.peer;
        bip_q   <= rdata_q.ip;
        bport_q <= rdata_q.port;
      end
    end else if (pair_eq && !found_q) begin
      pick_q <= ridx_q;
    end
  end

  // Commit decision
  assign dl_inc = (best_q == cit_pkg::DL_MAX) ? best_q : best_q + cit_pkg::DL_W'(1);

  always_comb begin
    status_d = cit_pkg::ST_NOT_FOUND;
    wr_en    = 1'b0;
    live_set = 1'b0;
    live_clr = 1'b0;
    wr_addr  = fill_q[cit_pkg::IDX_W-1:0];
    wr_data  = '{content: content_q, peer: peer_q, ip: ip_q, port: port_q,
                 downloads: '0};
    case (mode_q)
      cit_pkg::MODE_REGISTER: begin
        if (found_q) begin
          status_d = cit_pkg::ST_DUPLICATE;
        end else if (fill_q == cit_pkg::CNT_W'(cit_pkg::DEPTH)) begin
          status_d = cit_pkg::ST_FULL;
        end else begin
          status_d = cit_pkg::ST_REGISTERED;
          wr_en    = cmd_i.finish;
          live_set = cmd_i.finish;
        end
      end
      cit_pkg::MODE_SEARCH: begin
        wr_addr = pick_q;
        wr_data = '{content: content_q, peer: bpeer_q, ip: bip_q, port: bport_q,
                    downloads: dl_inc};
        if (hit_q) begin
          status_d = cit_pkg::ST_FOUND;
          wr_en    = cmd_i.finish;
        end
      end
      cit_pkg::MODE_DEREGISTER: begin
        if (found_q) begin
          status_d = cit_pkg::ST_DEREGISTERED;
          live_clr = cmd_i.finish;
        end else begin
          status_d = cit_pkg::ST_NOT_REGISTERED;
        end
      end
      default: begin
        status_d = cit_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Live bits and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      fill_q <= '0;
    end else begin
      if (live_set) begin
        live_q[fill_q[cit_pkg::IDX_W-1:0]] <= 1'b1;
        fill_q <= fill_q + cit_pkg::CNT_W'(1);
      end
      if (live_clr) live_q[pick_q] <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= status_d;
      out_peer_q   <= (status_d == cit_pkg::ST_FOUND) ? bpeer_q : '0;
      out_ip_q     <= (status_d == cit_pkg::ST_FOUND) ? bip_q   : '0;
      out_port_q   <= (status_d == cit_pkg::ST_FOUND) ? bport_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_peer_o = out_peer_q;
  assign found_ip_o   = out_ip_q;
  assign found_port_o = out_port_q;

  // Fill count never passes the table depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cit_pkg::CNT_W'(cit_pkg::DEPTH))
    else $error("fill count past depth");

  // A result word is only loaded into a free register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten");

  // A successful register grows the fill count by one
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_set |=> (fill_q == $past(fill_q) + cit_pkg::CNT_W'(1)))
    else $error("fill count did not step");

  // A search hit always points at a live slot
  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (mode_q == cit_pkg::MODE_SEARCH) && hit_q) |-> live_q[pick_q])
    else $error("search picked a dead slot");

endmodule

// ===== design/content_index_table_unit.sv =====
// Top level of the content index table: sequencer plus datapath.
//
// A table of up to 256 content registrations (content key, peer key, IPv4
// address, port, download count). Request words enter on the in channel
// (valid/ready) with mode register, search or deregister; the unused mode
// is taken and dropped without a result word. Each other request gives one
// result word on the out channel (valid/ready) with a status and, on a
// search hit, the chosen peer, address and port (zero otherwise).
// The download ceiling is written over the cfg channel, which is always
// ready; write it only while no request is in flight.
// Every request scans the filled slots one per cycle through the single read
// port of the slot memory before its result word is loaded; one request is
// handled at a time, and the next request is taken only once the last is done.
// A new request is taken while a finished result word still waits; if the
// receiver stalls, the next request completes its scan and then holds until
// the result register is free.
// Reset empties the table (all slots dead, fill count zero) and sets the
// ceiling to 999; no clearing pass is needed.
module content_index_table_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cit_pkg::MODE_W-1:0]  mode_i,
  input  logic [cit_pkg::KEY_W-1:0]   content_key_i,
  input  logic [cit_pkg::KEY_W-1:0]   peer_key_i,
  input  logic [cit_pkg::IP_W-1:0]    peer_ip_i,
  input  logic [cit_pkg::PORT_W-1:0]  peer_port_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cit_pkg::STAT_W-1:0]  status_o,
  output logic [cit_pkg::KEY_W-1:0]   found_peer_o,
  output logic [cit_pkg::IP_W-1:0]    found_ip_o,
  output logic [cit_pkg::PORT_W-1:0]  found_port_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cit_pkg::DL_W-1:0]    cfg_data_i
);

  cit_pkg::cit_cmd_t cmd;
  cit_pkg::cit_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  cit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table datapath
  cit_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .content_key_i (content_key_i),
    .peer_key_i    (peer_key_i),
    .peer_ip_i     (peer_ip_i),
    .peer_port_i   (peer_port_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_peer_o  (found_peer_o),
    .found_ip_o    (found_ip_o),
    .found_port_o  (found_port_o)
  );

endmodule

// ===== verif/tb_content_index_table_unit.sv =====
// Self-checking testbench for the content index table unit: directed table, then random phases.
module tb_content_index_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cit_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  localparam int unsigned SETTLE_CYCLES  = DEPTH + 40;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned HOLD_AFTER     = 600;
  localparam int unsigned CLIMB_SEARCHES = 1030;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  content;
    logic [KEY_W-1:0]  peer;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } cit_request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  peer;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } cit_reply_t;

  typedef struct {
    cit_request_t rq;
    bit           typed;
    cit_reply_t   rp;
  } stim_row_t;

  // DUT connections
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [MODE_W-1:0] mode_i        = '0;
  logic [KEY_W-1:0]  content_key_i = '0;
  logic [KEY_W-1:0]  peer_key_i    = '0;
  logic [IP_W-1:0]   peer_ip_i     = '0;
  logic [PORT_W-1:0] peer_port_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [KEY_W-1:0]  found_peer_o;
  logic [IP_W-1:0]   found_ip_o;
  logic [PORT_W-1:0] found_port_o;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [DL_W-1:0]   cfg_data_i    = '0;

  content_index_table_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .content_key_i (content_key_i),
    .peer_key_i    (peer_key_i),
    .peer_ip_i     (peer_ip_i),
    .peer_port_i   (peer_port_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_peer_o  (found_peer_o),
    .found_ip_o    (found_ip_o),
    .found_port_o  (found_port_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the table and the ceiling
  bit                t_live    [DEPTH];
  logic [KEY_W-1:0]  t_content [DEPTH];
  logic [KEY_W-1:0]  t_peer    [DEPTH];
  logic [IP_W-1:0]   t_ip      [DEPTH];
  logic [PORT_W-1:0] t_port    [DEPTH];
  logic [DL_W-1:0]   t_count   [DEPTH];
  int                t_fill    = 0;
  logic [DL_W-1:0]   t_ceiling = CEIL_DEFAULT;

  cit_reply_t        pending_replies[$];
  stim_row_t         dir_rows[$];
  cit_reply_t        no_reply;
  logic [KEY_W-1:0]  content_pool[8];
  logic [KEY_W-1:0]  peer_pool[6];

  int words_sent       = 0;
  int ignored_sent     = 0;
  int words_checked    = 0;
  int fail_count       = 0;
  int ceilings_written = 0;
  int tx_calm          = 0;
  int rx_calm          = 0;
  int status_tally[ST_NOT_REGISTERED+1];

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom, $urandom};
  endfunction

  function automatic cit_request_t make_request(input logic [MODE_W-1:0] m,
                                                input logic [KEY_W-1:0] c,
                                                input logic [KEY_W-1:0] p,
                                                input logic [IP_W-1:0] ip,
                                                input logic [PORT_W-1:0] port);
    cit_request_t rq;
    rq.mode = m; rq.content = c; rq.peer = p; rq.ip = ip; rq.port = port;
    return rq;
  endfunction

  // Directed rows: open rows are checked against the shadow table
  function automatic void add_row(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] c,
                                  input logic [KEY_W-1:0] p, input logic [IP_W-1:0] ip,
                                  input logic [PORT_W-1:0] port);
    stim_row_t row;
    row.rq    = make_request(m, c, p, ip, port);
    row.typed = 1'b0;
    row.rp    = no_reply;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(input logic [MODE_W-1:0] m,
                                          input logic [KEY_W-1:0] c, input logic [KEY_W-1:0] p,
                                          input logic [IP_W-1:0] ip,
                                          input logic [PORT_W-1:0] port,
                                          input logic [STAT_W-1:0] st,
                                          input logic [KEY_W-1:0] fp, input logic [IP_W-1:0] fi,
                                          input logic [PORT_W-1:0] fo);
    add_row(m, c, p, ip, port);
    dir_rows[$].typed     = 1'b1;
    dir_rows[$].rp.status = st;
    dir_rows[$].rp.peer   = fp;
    dir_rows[$].rp.ip     = fi;
    dir_rows[$].rp.port   = fo;
  endfunction

  // First live slot holding this content/peer pair, -1 if none
  function automatic int find_live_pair(input logic [KEY_W-1:0] c, input logic [KEY_W-1:0] p);
    for (int i = 0; i < t_fill; i++) begin
      if (t_live[i] && t_content[i] == c && t_peer[i] == p) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table; returns 0 when no word is due
  function automatic bit table_outcome(input cit_request_t rq, output cit_reply_t rp);
    int              k;
    bit              hit;
    logic [DL_W-1:0] best;
    rp.status = ST_NOT_FOUND;
    rp.peer   = '0;
    rp.ip     = '0;
    rp.port   = '0;
    hit  = 1'b0;
    k    = 0;
    best = t_ceiling;
    case (rq.mode)
      MODE_REGISTER: begin
        if (find_live_pair(rq.content, rq.peer) >= 0) begin
          rp.status = ST_DUPLICATE;
        end else if (t_fill >= int'(DEPTH)) begin
          rp.status = ST_FULL;
        end else begin
          t_live[t_fill]    = 1'b1;
          t_content[t_fill] = rq.content;
          t_peer[t_fill]    = rq.peer;
          t_ip[t_fill]      = rq.ip;
          t_port[t_fill]    = rq.port;
          t_count[t_fill]   = '0;
          t_fill++;
          rp.status = ST_REGISTERED;
        end
      end
      MODE_SEARCH: begin
        // least count below the ceiling, lowest slot on a tie
        for (int i = 0; i < t_fill; i++) begin
          if (t_live[i] && t_content[i] == rq.content && t_count[i] < best) begin
            best = t_count[i];
            k    = i;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          rp.status = ST_FOUND;
          rp.peer   = t_peer[k];
          rp.ip     = t_ip[k];
          rp.port   = t_port[k];
          if (t_count[k] != DL_MAX) t_count[k] = t_count[k] + 1'b1;
        end
      end
      MODE_DEREGISTER: begin
        k = find_live_pair(rq.content, rq.peer);
        if (k >= 0) begin
          t_live[k] = 1'b0;
          rp.status = ST_DEREGISTERED;
        end else begin
          rp.status = ST_NOT_REGISTERED;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, a few long, with calm runs of none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = int'($urandom_range(99));
    if (r < 2) calm = int'($urandom_range(60, 20));
    if (r < 60) return 0;
    if (r < 90) return int'($urandom_range(3, 1));
    if (r < 98) return int'($urandom_range(12, 4));
    return int'($urandom_range(60, 20));
  endfunction

  // Mostly pooled keys so that pairs recur; some fresh keys and unused modes
  function automatic cit_request_t random_request();
    cit_request_t rq;
    int           r;
    r = int'($urandom_range(99));
    if (r < 45)      rq.mode = MODE_REGISTER;
    else if (r < 75) rq.mode = MODE_SEARCH;
    else if (r < 95) rq.mode = MODE_DEREGISTER;
    else             rq.mode = MODE_NONE;
    rq.content = ($urandom_range(99) < 75) ? content_pool[$urandom_range(7)] : any_key();
    rq.peer    = ($urandom_range(99) < 75) ? peer_pool[$urandom_range(5)] : any_key();
    rq.ip      = $urandom;
    if ($urandom_range(19) == 0) rq.ip = ($urandom_range(1) == 1) ? {IP_W{1'b1}} : '0;
    rq.port    = PORT_W'($urandom);
    if ($urandom_range(19) == 0) rq.port = ($urandom_range(1) == 1) ? {PORT_W{1'b1}} : '0;
    return rq;
  endfunction

  // Offer one request word and hold it until taken
  task automatic offer_request(input cit_request_t rq, input bit typed,
                               input cit_reply_t typed_rp);
    cit_reply_t rp;
    bit         go;
    int         gap;
    in_valid_i    <= 1'b1;
    mode_i        <= rq.mode;
    content_key_i <= rq.content;
    peer_key_i    <= rq.peer;
    peer_ip_i     <= rq.ip;
    peer_port_i   <= rq.port;
    do begin
      @(negedge clk_i);
      go = in_ready_o;
      @(posedge clk_i);
    end while (!go);
    words_sent++;
    if (table_outcome(rq, rp)) pending_replies.push_back(typed ? typed_rp : rp);
    else ignored_sent++;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Let every outstanding request finish and deliver its result word, then settle
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ceiling(input logic [DL_W-1:0] value);
    bit go;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      go = cfg_ready_o;
      @(posedge clk_i);
    end while (!go);
    cfg_valid_i <= 1'b0;
    t_ceiling = value;
    ceilings_written++;
  endtask

  task automatic run_phase(input logic [DL_W-1:0] ceiling, input int count);
    cit_request_t rq;
    int           counted;
    counted = 0;
    drain_requests();
    set_ceiling(ceiling);
    while (counted < count) begin
      rq = random_request();
      offer_request(rq, 1'b0, no_reply);
      if (rq.mode != MODE_NONE) counted++;
    end
  endtask

  // Result side: random back-pressure, one long hold-off, compare against oldest expectation
  initial begin : result_sink
    int         stall_left;
    int         hold_left;
    bit         held;
    cit_reply_t got;
    cit_reply_t want;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (!held && words_checked >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (stall_left == 0) stall_left = pick_gap(rx_calm);
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
      @(negedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        got.status = status_o;
        got.peer   = found_peer_o;
        got.ip     = found_ip_o;
        got.port   = found_port_o;
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result word: status %0d peer %h ip %h port %h",
                     got.status, got.peer, got.ip, got.port);
        end else begin
          want = pending_replies.pop_front();
          status_tally[want.status]++;
          if (got.status !== want.status || got.peer !== want.peer ||
              got.ip !== want.ip || got.port !== want.port) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"word %0d: expected status %0d peer %h ip %h port %h,",
                        " got status %0d peer %h ip %h port %h"},
                       words_checked, want.status, want.peer, want.ip, want.port,
                       got.status, got.peer, got.ip, got.port);
          end
        end
        words_checked++;
      end
      @(posedge clk_i);
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles,
             pending_replies.size());
    $display("** content_index_table_unit: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [KEY_W-1:0] hot;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] peer_1;
    logic [KEY_W-1:0] peer_2;
    int               top_count;
    foreach (status_tally[i]) status_tally[i] = 0;
    content_pool[0] = '0;
    content_pool[1] = '1;
    for (int i = 2; i < 8; i++) content_pool[i] = any_key();
    peer_pool[0] = '0;
    peer_pool[1] = '1;
    for (int i = 2; i < 6; i++) peer_pool[i] = any_key();
    key_a  = 64'h0123_4567_89ab_cdef;
    peer_1 = 64'h5a5a_5a5a_5a5a_5a5a;
    peer_2 = 64'ha5a5_a5a5_a5a5_a5a5;

    // empty table, extremes, ties, drop of the unused mode, reuse after deregister
    add_checked_row(MODE_SEARCH, '0, '1, '1, '1, ST_NOT_FOUND, '0, '0, '0);
    add_checked_row(MODE_DEREGISTER, '0, '0, '0, '0, ST_NOT_REGISTERED, '0, '0, '0);
    add_checked_row(MODE_REGISTER, '0, '0, '0, '0, ST_REGISTERED, '0, '0, '0);
    add_checked_row(MODE_REGISTER, '1, '1, '1, '1, ST_REGISTERED, '0, '0, '0);
    add_checked_row(MODE_REGISTER, '0, '0, 32'h1234_5678, 16'h9abc, ST_DUPLICATE,
                    '0, '0, '0);
    add_checked_row(MODE_SEARCH, '1, '0, '0, '0, ST_FOUND, '1, '1, '1);
    add_checked_row(MODE_SEARCH, '0, '1, '1, '1, ST_FOUND, '0, '0, '0);
    add_checked_row(MODE_REGISTER, key_a, peer_1, 32'hc0a8_0001, 16'd8080, ST_REGISTERED,
                    '0, '0, '0);
    add_checked_row(MODE_REGISTER, key_a, peer_2, 32'h0a00_0002, 16'd22, ST_REGISTERED,
                    '0, '0, '0);
    add_row(MODE_SEARCH, key_a, '0, '0, '0);
    add_row(MODE_SEARCH, key_a, '1, '1, '1);
    add_row(MODE_SEARCH, key_a, peer_2, '0, '0);
    add_row(MODE_NONE, key_a, peer_1, '1, '1);
    add_checked_row(MODE_DEREGISTER, key_a, peer_1, '0, '0, ST_DEREGISTERED, '0, '0, '0);
    add_row(MODE_SEARCH, key_a, peer_1, '0, '0);
    add_checked_row(MODE_DEREGISTER, key_a, peer_1, '0, '0, ST_NOT_REGISTERED,
                    '0, '0, '0);
    add_checked_row(MODE_REGISTER, key_a, peer_1, 32'h8000_0000, 16'h8000, ST_REGISTERED,
                    '0, '0, '0);
    add_row(MODE_SEARCH, key_a, '0, '0, '0);
    add_checked_row(MODE_REGISTER, '1, '0, 32'h7fff_ffff, 16'h7fff, ST_REGISTERED,
                    '0, '0, '0);
    add_row(MODE_SEARCH, '1, any_key(), $urandom, PORT_W'($urandom));
    add_checked_row(MODE_DEREGISTER, '1, '1, '0, '0, ST_DEREGISTERED, '0, '0, '0);
    add_checked_row(MODE_DEREGISTER, '0, '0, '1, '1, ST_DEREGISTERED, '0, '0, '0);
    add_checked_row(MODE_SEARCH, '0, '0, '0, '0, ST_NOT_FOUND, '0, '0, '0);
    add_row(MODE_NONE, '1, '1, '1, '1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) offer_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rp);

    // one entry searched until its count tops out at the largest ceiling,
    // while fresh pairs fill the table past its depth
    drain_requests();
    set_ceiling(DL_MAX);
    hot = any_key();
    offer_request(make_request(MODE_REGISTER, hot, any_key(), $urandom, PORT_W'($urandom)),
                  1'b0, no_reply);
    for (int n = 0; n < CLIMB_SEARCHES; n++) begin
      if (n % 97 == 50)
        offer_request(make_request(MODE_NONE, hot, any_key(), $urandom, PORT_W'($urandom)),
                      1'b0, no_reply);
      if (n % 4 == 0)
        offer_request(make_request(MODE_REGISTER, any_key(), any_key(), $urandom,
                                   PORT_W'($urandom)), 1'b0, no_reply);
      offer_request(make_request(MODE_SEARCH, hot, any_key(), $urandom, PORT_W'($urandom)),
                    1'b0, no_reply);
    end

    // random phases over a spread of ceilings
    run_phase(DL_MAX, 45);
    run_phase('0, 20);
    run_phase(DL_W'(1), 30);
    run_phase(DL_W'($urandom_range(6, 2)), 30);
    run_phase(DL_W'($urandom_range(1023, 0)), 20);
    run_phase(CEIL_DEFAULT, 25);
    drain_requests();

    top_count = 0;
    for (int i = 0; i < t_fill; i++)
      if (int'(t_count[i]) > top_count) top_count = int'(t_count[i]);
    $display("%0d request words (%0d of the unused mode), %0d results, %0d ceiling writes,",
             words_sent, ignored_sent, words_checked, ceilings_written);
    $display({"table filled to %0d, top count %0d; registered %0d dup %0d full %0d",
              " found %0d miss %0d dereg %0d unknown %0d"},
             t_fill, top_count, status_tally[ST_REGISTERED], status_tally[ST_DUPLICATE],
             status_tally[ST_FULL], status_tally[ST_FOUND], status_tally[ST_NOT_FOUND],
             status_tally[ST_DEREGISTERED], status_tally[ST_NOT_REGISTERED]);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("** content_index_table_unit: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** content_index_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
